@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file lu_inv_chk.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

@@ rtl/lu_inv_pkg.sv @@
// Package for the 3x3 LU matrix inverter: types, address map, microprogram.
// No dependencies.
package lu_inv_pkg;

    localparam int DIM       = 3;
    localparam int CELLS     = DIM * DIM;
    localparam int AW        = 6;
    localparam int RAM_DEPTH = 64;
    localparam int ACCW      = 35;
    localparam int NUM_INSTR = 30;
    localparam int PCW       = 5;

    localparam logic [AW-1:0] A_BASE   = 6'd0;
    localparam logic [AW-1:0] L_BASE   = 6'd9;
    localparam logic [AW-1:0] U_BASE   = 6'd18;
    localparam logic [AW-1:0] LI_BASE  = 6'd27;
    localparam logic [AW-1:0] UI_BASE  = 6'd36;
    localparam logic [AW-1:0] INV_BASE = 6'd45;

    localparam logic [PCW-1:0] LAST_PC   = 5'(NUM_INSTR - 1);
    localparam logic [3:0]     LAST_CELL = 4'(CELLS - 1);

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        M_SUB,  // sat(base - sum)
        M_NEG,  // -sat(sum)
        M_SAT,  // sat(sum)
        M_ONE   // fixed-point one
    } mode_t;

    typedef struct packed {
        logic [1:0]           nprod;
        logic [2:0][AW-1:0]   pa;
        logic [2:0][AW-1:0]   pb;
        mode_t                mode;
        logic [AW-1:0]        base;
        logic                 dodiv;
        logic [AW-1:0]        daddr;
        logic [AW-1:0]        dest;
        logic                 pivot;
    } instr_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FETCH,
        ST_RDA,
        ST_RDB,
        ST_MUL,
        ST_ACC,
        ST_BASE,
        ST_FORM,
        ST_DRD,
        ST_DSTART,
        ST_DWAIT,
        ST_WR,
        ST_ORD,
        ST_OCAP,
        ST_OWAIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [AW-1:0] ad(input logic [AW-1:0] base, input int r, input int c);
        return base + AW'(r * DIM + c);
    endfunction

    function automatic instr_t mk(
        input logic [1:0]    n,
        input mode_t         m,
        input logic [AW-1:0] base,
        input logic [AW-1:0] a0, input logic [AW-1:0] b0,
        input logic [AW-1:0] a1, input logic [AW-1:0] b1,
        input logic [AW-1:0] a2, input logic [AW-1:0] b2,
        input logic          dv,
        input logic [AW-1:0] d,
        input logic [AW-1:0] dest,
        input logic          piv
    );
        instr_t i;
        i.nprod = n;
        i.pa    = {a2, a1, a0};
        i.pb    = {b2, b1, b0};
        i.mode  = m;
        i.base  = base;
        i.dodiv = dv;
        i.daddr = d;
        i.dest  = dest;
        i.pivot = piv;
        return i;
    endfunction

    // Doolittle factorization, triangular inverses, then inv(U) * inv(L).
    // Products against known zeros are left out; they add exactly zero.
    function automatic instr_t prog_rom(input logic [PCW-1:0] pc);
        instr_t r;
        localparam logic [AW-1:0] Z = '0;
        case (pc)
            5'd0:  r = mk(2'd0, M_SUB, ad(A_BASE,0,0), Z,Z,Z,Z,Z,Z, 1'b0, Z,
                          ad(U_BASE,0,0), 1'b1);
            5'd1:  r = mk(2'd0, M_SUB, ad(A_BASE,0,1), Z,Z,Z,Z,Z,Z, 1'b0, Z,
                          ad(U_BASE,0,1), 1'b0);
            5'd2:  r = mk(2'd0, M_SUB, ad(A_BASE,0,2), Z,Z,Z,Z,Z,Z, 1'b0, Z,
                          ad(U_BASE,0,2), 1'b0);
            5'd3:  r = mk(2'd0, M_SUB, ad(A_BASE,1,0), Z,Z,Z,Z,Z,Z, 1'b1,
                          ad(U_BASE,0,0), ad(L_BASE,1,0), 1'b0);
            5'd4:  r = mk(2'd0, M_SUB, ad(A_BASE,2,0), Z,Z,Z,Z,Z,Z, 1'b1,
                          ad(U_BASE,0,0), ad(L_BASE,2,0), 1'b0);
            5'd5:  r = mk(2'd1, M_SUB, ad(A_BASE,1,1),
                          ad(L_BASE,1,0), ad(U_BASE,0,1), Z,Z,Z,Z, 1'b0, Z,
                          ad(U_BASE,1,1), 1'b1);
            5'd6:  r = mk(2'd1, M_SUB, ad(A_BASE,1,2),
                          ad(L_BASE,1,0), ad(U_BASE,0,2), Z,Z,Z,Z, 1'b0, Z,
                          ad(U_BASE,1,2), 1'b0);
            5'd7:  r = mk(2'd1, M_SUB, ad(A_BASE,2,1),
                          ad(L_BASE,2,0), ad(U_BASE,0,1), Z,Z,Z,Z, 1'b1,
                          ad(U_BASE,1,1), ad(L_BASE,2,1), 1'b0);
            5'd8:  r = mk(2'd2, M_SUB, ad(A_BASE,2,2),
                          ad(L_BASE,2,0), ad(U_BASE,0,2),
                          ad(L_BASE,2,1), ad(U_BASE,1,2), Z,Z, 1'b0, Z,
                          ad(U_BASE,2,2), 1'b1);
            5'd9:  r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b0, Z, ad(LI_BASE,0,0), 1'b0);
            5'd10: r = mk(2'd1, M_NEG, Z, ad(L_BASE,1,0), ad(LI_BASE,0,0), Z,Z,Z,Z,
                          1'b0, Z, ad(LI_BASE,1,0), 1'b0);
            5'd11: r = mk(2'd2, M_NEG, Z, ad(L_BASE,2,0), ad(LI_BASE,0,0),
                          ad(L_BASE,2,1), ad(LI_BASE,1,0), Z,Z,
                          1'b0, Z, ad(LI_BASE,2,0), 1'b0);
            5'd12: r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b0, Z, ad(LI_BASE,1,1), 1'b0);
            5'd13: r = mk(2'd1, M_NEG, Z, ad(L_BASE,2,1), ad(LI_BASE,1,1), Z,Z,Z,Z,
                          1'b0, Z, ad(LI_BASE,2,1), 1'b0);
            5'd14: r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b0, Z, ad(LI_BASE,2,2), 1'b0);
            5'd15: r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b1, ad(U_BASE,0,0),
                          ad(UI_BASE,0,0), 1'b0);
            5'd16: r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b1, ad(U_BASE,1,1),
                          ad(UI_BASE,1,1), 1'b0);
            5'd17: r = mk(2'd1, M_NEG, Z, ad(U_BASE,0,1), ad(UI_BASE,1,1), Z,Z,Z,Z,
                          1'b1, ad(U_BASE,0,0), ad(UI_BASE,0,1), 1'b0);
            5'd18: r = mk(2'd0, M_ONE, Z, Z,Z,Z,Z,Z,Z, 1'b1, ad(U_BASE,2,2),
                          ad(UI_BASE,2,2), 1'b0);
            5'd19: r = mk(2'd1, M_NEG, Z, ad(U_BASE,1,2), ad(UI_BASE,2,2), Z,Z,Z,Z,
                          1'b1, ad(U_BASE,1,1), ad(UI_BASE,1,2), 1'b0);
            5'd20: r = mk(2'd2, M_NEG, Z, ad(U_BASE,0,1), ad(UI_BASE,1,2),
                          ad(U_BASE,0,2), ad(UI_BASE,2,2), Z,Z,
                          1'b1, ad(U_BASE,0,0), ad(UI_BASE,0,2), 1'b0);
            5'd21: r = mk(2'd3, M_SAT, Z, ad(UI_BASE,0,0), ad(LI_BASE,0,0),
                          ad(UI_BASE,0,1), ad(LI_BASE,1,0),
                          ad(UI_BASE,0,2), ad(LI_BASE,2,0),
                          1'b0, Z, ad(INV_BASE,0,0), 1'b0);
            5'd22: r = mk(2'd2, M_SAT, Z, ad(UI_BASE,0,1), ad(LI_BASE,1,1),
                          ad(UI_BASE,0,2), ad(LI_BASE,2,1), Z,Z,
                          1'b0, Z, ad(INV_BASE,0,1), 1'b0);
            5'd23: r = mk(2'd1, M_SAT, Z, ad(UI_BASE,0,2), ad(LI_BASE,2,2), Z,Z,Z,Z,
                          1'b0, Z, ad(INV_BASE,0,2), 1'b0);
            5'd24: r = mk(2'd2, M_SAT, Z, ad(UI_BASE,1,1), ad(LI_BASE,1,0),
                          ad(UI_BASE,1,2), ad(LI_BASE,2,0), Z,Z,
                          1'b0, Z, ad(INV_BASE,1,0), 1'b0);
            5'd25: r = mk(2'd2, M_SAT, Z, ad(UI_BASE,1,1), ad(LI_BASE,1,1),
                          ad(UI_BASE,1,2), ad(LI_BASE,2,1), Z,Z,
                          1'b0, Z, ad(INV_BASE,1,1), 1'b0);
            5'd26: r = mk(2'd1, M_SAT, Z, ad(UI_BASE,1,2), ad(LI_BASE,2,2), Z,Z,Z,Z,
                          1'b0, Z, ad(INV_BASE,1,2), 1'b0);
            5'd27: r = mk(2'd1, M_SAT, Z, ad(UI_BASE,2,2), ad(LI_BASE,2,0), Z,Z,Z,Z,
                          1'b0, Z, ad(INV_BASE,2,0), 1'b0);
            5'd28: r = mk(2'd1, M_SAT, Z, ad(UI_BASE,2,2), ad(LI_BASE,2,1), Z,Z,Z,Z,
                          1'b0, Z, ad(INV_BASE,2,1), 1'b0);
            5'd29: r = mk(2'd1, M_SAT, Z, ad(UI_BASE,2,2), ad(LI_BASE,2,2), Z,Z,Z,Z,
                          1'b0, Z, ad(INV_BASE,2,2), 1'b0);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/lu_inv_in_if.sv @@
// Input channel of the matrix inverter: one matrix element per transaction.
// No dependencies.
interface lu_inv_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] elem_in;
    logic               elem_last;

    modport source (output valid, output elem_in, output elem_last, input ready);
    modport sink   (input valid, input elem_in, input elem_last, output ready);
endinterface

@@ rtl/lu_inv_out_if.sv @@
// Output channel of the matrix inverter: one inverse element per transaction.
// No dependencies.
interface lu_inv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] elem_out;
    logic               singular;
    logic               out_last;

    modport source (output valid, output elem_out, output singular, output out_last,
                    input ready);
    modport sink   (input valid, input elem_out, input singular, input out_last,
                    output ready);
endinterface

@@ rtl/lu_inv_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lu_inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lu_inv_div.sv @@
// Radix-2 restoring divider for fixed-point quotients, rounded half away from
// zero and saturated to 32 bits. Depends on lu_inv_pkg.
module lu_inv_div
    import lu_inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    localparam int QW = 33 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [QW-1:0] q_reg, q_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   ub_reg, ub_next;
    logic          neg_reg, neg_next;

    logic [31:0]   mag_n, mag_d;
    logic [32:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        mag_n  = num[31] ? 32'(-num) : 32'(num);
        mag_d  = den[31] ? 32'(-den) : 32'(den);
        rem_sh = {rem_reg, dvd_reg[QW-1]};
        ge     = rem_sh >= {1'b0, ub_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // |num| * 2^F plus half the divisor gives the rounded quotient
            dvd_next  = {1'b0, mag_n, {FRAC_BITS{1'b0}}} + QW'(mag_d >> 1);
            q_next    = '0;
            rem_next  = '0;
            ub_next   = mag_d;
            neg_next  = num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(rem_sh - {1'b0, ub_reg}) : rem_sh[31:0];
            q_next   = {q_reg[QW-2:0], ge};
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (|q_reg[QW-1:31])
            quo = neg_reg ? S32_MIN : S32_MAX;
        else
            quo = neg_reg ? -$signed(q_reg[31:0]) : $signed(q_reg[31:0]);
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
    end
endmodule

@@ rtl/lu_matrix_inverse_3x3_unit.sv @@
// 3x3 matrix inverter: loads 9 elements, then a 30-step microprogram reads and writes
// one shared RAM; each step fetches, then per product reads both operands, multiplies
// and accumulates, forms the value, divides if flagged (9 steps do) and writes back.
// Results leave singly and wait to be taken; the next matrix loads after the last one.
// Sequential: one matrix at a time. Reset clears control state only; RAM is not
// cleared. Depends on lu_inv_pkg, lu_inv_in_if, lu_inv_out_if, lu_inv_ram, lu_inv_div.
module lu_matrix_inverse_3x3_unit
    import lu_inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    lu_inv_in_if.sink    in_ch,
    lu_inv_out_if.source out_ch
);
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    state_t state_reg, state_next;

    logic [3:0]           cnt_reg;
    logic [PCW-1:0]       pc_reg;
    logic [1:0]           pidx_reg;
    logic [3:0]           oidx_reg;
    logic                 sing_reg;
    instr_t               instr_reg;
    logic signed [31:0]   opa_reg;
    logic signed [63:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [31:0]   val_reg;
    logic signed [31:0]   out_data_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata, ram_rdata;
    logic                 div_start, div_done;
    logic signed [31:0]   div_quo;

    logic                 in_acc, out_acc;
    logic signed [31:0]   prod_r32;
    logic signed [63:0]   prod_rnd;
    logic signed [31:0]   acc_sat;
    logic signed [31:0]   form_val;
    instr_t               fetch_instr;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign fetch_instr = prog_rom(pc_reg);

    lu_inv_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lu_inv_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (val_reg),
        .den   ($signed(ram_rdata)),
        .done  (div_done),
        .quo   (div_quo)
    );

    // arithmetic
    always_comb
    begin
        prod_rnd = (prod_reg + HALF) >>> FRAC_BITS;
        prod_r32 = sat32(prod_rnd);
        acc_sat  = sat32(64'(acc_reg));
        case (instr_reg.mode)
            M_SUB:   form_val = sat32(64'($signed(ram_rdata)) - 64'(acc_reg));
            M_NEG:   form_val = (acc_sat == S32_MIN) ? S32_MAX : -acc_sat;
            M_SAT:   form_val = acc_sat;
            M_ONE:   form_val = ONE;
            default: form_val = acc_sat;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:   if (in_acc && in_ch.elem_last) state_next = ST_FETCH;
            ST_FETCH:  state_next = (fetch_instr.nprod != 2'd0) ? ST_RDA : ST_BASE;
            ST_RDA:    state_next = ST_RDB;
            ST_RDB:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = ({1'b0, pidx_reg} + 3'd1 < {1'b0, instr_reg.nprod})
                                    ? ST_RDA : ST_BASE;
            ST_BASE:   state_next = ST_FORM;
            ST_FORM:   state_next = instr_reg.dodiv ? ST_DRD : ST_WR;
            ST_DRD:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = ST_WR;
            ST_WR:
            begin
                if ((instr_reg.pivot && val_reg == 32'sd0) || pc_reg == LAST_PC)
                    state_next = ST_ORD;
                else
                    state_next = ST_FETCH;
            end
            ST_ORD:    state_next = ST_OCAP;
            ST_OCAP:   state_next = ST_OWAIT;
            ST_OWAIT:
            begin
                if (out_acc)
                    state_next = (oidx_reg == LAST_CELL) ? ST_LOAD : ST_ORD;
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = instr_reg.dest;
        ram_wdata   = val_reg;
        ram_raddr   = instr_reg.base;
        div_start   = 1'b0;
        in_ch.ready = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ch.ready = 1'b1;
                ram_we      = in_acc && (cnt_reg < 4'(CELLS));
                ram_waddr   = A_BASE + AW'(cnt_reg);
                ram_wdata   = in_ch.elem_in;
            end
            ST_RDA:    ram_raddr = instr_reg.pa[pidx_reg];
            ST_RDB:    ram_raddr = instr_reg.pb[pidx_reg];
            ST_DRD:    ram_raddr = instr_reg.daddr;
            ST_DSTART: div_start = 1'b1;
            ST_WR:     ram_we    = 1'b1;
            ST_ORD:    ram_raddr = INV_BASE + AW'(oidx_reg);
            ST_OWAIT:  out_ch.valid = 1'b1;
            default:   ram_we = 1'b0;
        endcase
    end

    assign out_ch.elem_out = out_data_reg;
    assign out_ch.singular = sing_reg;
    assign out_ch.out_last = (oidx_reg == LAST_CELL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            pidx_reg  <= '0;
            oidx_reg  <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (in_ch.elem_last)
                        begin
                            cnt_reg  <= '0;
                            pc_reg   <= '0;
                            sing_reg <= 1'b0;
                        end
                        else if (cnt_reg < 4'(CELLS))
                        begin
                            cnt_reg <= cnt_reg + 4'd1;
                        end
                    end
                end
                ST_FETCH: pidx_reg <= '0;
                ST_ACC:   pidx_reg <= pidx_reg + 2'd1;
                ST_WR:
                begin
                    oidx_reg <= '0;
                    pc_reg   <= pc_reg + 5'd1;
                    if (instr_reg.pivot && val_reg == 32'sd0)
                        sing_reg <= 1'b1;
                end
                ST_OWAIT: if (out_acc) oidx_reg <= oidx_reg + 4'd1;
                default:  pidx_reg <= pidx_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FETCH:
            begin
                instr_reg <= fetch_instr;
                acc_reg   <= '0;
            end
            ST_RDB:   opa_reg  <= $signed(ram_rdata);
            ST_MUL:   prod_reg <= opa_reg * $signed(ram_rdata);
            ST_ACC:   acc_reg  <= acc_reg + ACCW'(prod_r32);
            ST_FORM:  val_reg  <= form_val;
            ST_DWAIT: if (div_done) val_reg <= div_quo;
            ST_OCAP:  out_data_reg <= sing_reg ? 32'sd0 : $signed(ram_rdata);
            default:  val_reg <= val_reg;
        endcase
    end
endmodule

@@ rtl/lu_inv_chk.sv @@
// Port-level checker for the matrix inverter, bound to the top level.
// Depends on assert_macros.svh and lu_matrix_inverse_3x3_unit.
`include "assert_macros.svh"

module lu_inv_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic [31:0] elem_out,
    input logic        singular
);
    // loading and delivering never overlap
    `ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
    // a final element stops intake until the burst has gone
    `ASSERT_NXT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
    // a singular matrix yields zeros
    `ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && singular, elem_out == 32'd0)
    // after the marked result the block takes elements again
    `ASSERT_NXT(a_reopen, clk, rst_n, out_valid && out_ready && out_last, in_ready)
    // a waiting result stays offered
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind lu_matrix_inverse_3x3_unit lu_inv_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.elem_last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.out_last),
    .elem_out  (out_ch.elem_out),
    .singular  (out_ch.singular)
);
